[hw/rtl/ncd_pkg.sv]
// Shared types and constants for the nearest-car dispatcher.
package ncd_pkg;

    // Width of a car index carried along the chain (covers up to 64 cars)
    localparam int CAR_IDX_W = 6;
    localparam int FLOOR_W   = 6;
    localparam int CFG_W     = 4;
    localparam int OUT_IDX_W = 3;

    // Input opcodes
    localparam logic OP_STATUS  = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Status entry of one car
    typedef struct packed {
        logic [FLOOR_W-1:0] floor;
        logic               direction;
        logic               moving;
        logic               active;
        logic               blocked;
    } car_status_t;

    // Request token handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic [FLOOR_W-1:0]   req_floor;
        logic                 req_direction;
        logic                 have_transit;
        logic [CAR_IDX_W-1:0] idx_transit;
        logic [FLOOR_W-1:0]   dist_transit;
        logic                 have_idle;
        logic [CAR_IDX_W-1:0] idx_idle;
        logic [FLOOR_W-1:0]   dist_idle;
    } scan_token_t;

endpackage

[hw/rtl/ncd_cell.sv]
// One car cell: holds the car's status and updates the passing request token.
module ncd_cell
    import ncd_pkg::*;
#(
    parameter int CELL_IDX = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        enabled,
    input  logic        status_we,
    input  car_status_t status_in,
    input  scan_token_t tok_in,
    output scan_token_t tok_out
);

    car_status_t status_reg;
    scan_token_t tok_reg;
    scan_token_t tok_next;

    logic [FLOOR_W-1:0] car_dist;
    logic               short_of;
    logic               transit_ok;
    logic               idle_ok;

    // Store the car's status on an update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= '0;
        end
        else if (status_we)
        begin
            status_reg <= status_in;
        end
    end

    // Distance and eligibility of this car for the passing request
    always_comb
    begin
        car_dist = (status_reg.floor > tok_in.req_floor) ?
                   (status_reg.floor - tok_in.req_floor) :
                   (tok_in.req_floor - status_reg.floor);
        short_of = tok_in.req_direction ? (status_reg.floor < tok_in.req_floor) :
                                          (status_reg.floor > tok_in.req_floor);
        transit_ok = enabled && status_reg.active && status_reg.moving &&
                     (status_reg.direction == tok_in.req_direction) && short_of;
        idle_ok = enabled && status_reg.active && !status_reg.blocked;
    end

    // Keep the best candidate of each kind; ties stay with the lower index
    always_comb
    begin
        tok_next = tok_in;
        if (transit_ok && (!tok_in.have_transit || car_dist < tok_in.dist_transit))
        begin
            tok_next.have_transit = 1'b1;
            tok_next.idx_transit  = CAR_IDX_W'(CELL_IDX);
            tok_next.dist_transit = car_dist;
        end
        if (idle_ok && (!tok_in.have_idle || car_dist < tok_in.dist_idle))
        begin
            tok_next.have_idle = 1'b1;
            tok_next.idx_idle  = CAR_IDX_W'(CELL_IDX);
            tok_next.dist_idle = car_dist;
        end
    end

    // Hand the token to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[hw/rtl/nearest_car_dispatch.sv]
// Nearest-car dispatcher: a status update is stored in the addressed cell's
// register and gives no result; a dispatch request walks a chain of MAX_CARS
// cells, one cell per car and one cell per cycle while the chain is not held,
// and its result is then captured in an output register. The block takes
// one request at a time: in_ready stays low while a request is in the chain,
// for status updates as well. A finished result waits in the output register;
// if it is not taken, a following request holds in the chain. cars_in_use
// limits the cells that may win; updates go to any car.
module nearest_car_dispatch
    import ncd_pkg::*;
#(
    parameter int MAX_CARS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 opcode,
    input  logic [2:0]           car_index,
    input  logic [FLOOR_W-1:0]   car_floor,
    input  logic                 car_direction,
    input  logic                 car_moving,
    input  logic                 car_active,
    input  logic                 car_blocked,
    input  logic [FLOOR_W-1:0]   request_floor,
    input  logic                 request_direction,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 found,
    output logic [OUT_IDX_W-1:0] chosen_car
);

    logic [CFG_W-1:0]     cars_in_use_reg;
    logic                 busy_reg;
    logic                 out_valid_reg;
    logic                 found_reg;
    logic [OUT_IDX_W-1:0] chosen_reg;

    logic                 accept;
    logic                 advance;
    logic                 finish;
    car_status_t          status_in;
    scan_token_t          head_tok;
    scan_token_t          chain [0:MAX_CARS];
    logic [MAX_CARS-1:0]  cell_en;
    logic [MAX_CARS-1:0]  cell_we;
    scan_token_t          last_tok;
    logic                 res_found;
    logic [OUT_IDX_W-1:0] res_idx;

    assign accept   = in_valid && in_ready;
    assign in_ready = !busy_reg;

    // Hold the chain when the final result cannot be delivered
    assign last_tok = chain[MAX_CARS];
    assign advance  = !(last_tok.valid && out_valid_reg && !out_ready);
    assign finish   = last_tok.valid && advance;

    // Car count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cars_in_use_reg <= CFG_W'(8);
        end
        else if (cfg_we)
        begin
            cars_in_use_reg <= cfg_wdata;
        end
    end

    // Form the token that enters the first cell
    always_comb
    begin
        head_tok               = '0;
        head_tok.valid         = accept && (opcode == OP_REQUEST);
        head_tok.req_floor     = request_floor;
        head_tok.req_direction = request_direction;
    end

    assign chain[0] = head_tok;

    assign status_in.floor     = car_floor;
    assign status_in.direction = car_direction;
    assign status_in.moving    = car_moving;
    assign status_in.active    = car_active;
    assign status_in.blocked   = car_blocked;

    // Row of car cells
    for (genvar g = 0; g < MAX_CARS; g++)
    begin : g_cell
        assign cell_en[g] = (32'(cars_in_use_reg) > g);
        assign cell_we[g] = accept && (opcode == OP_STATUS) && (32'(car_index) == g);

        ncd_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .enabled   (cell_en[g]),
            .status_we (cell_we[g]),
            .status_in (status_in),
            .tok_in    (chain[g]),
            .tok_out   (chain[g+1])
        );
    end

    // Pick the in-transit winner, else the idle winner
    always_comb
    begin
        res_found = last_tok.have_transit || last_tok.have_idle;
        if (last_tok.have_transit)
        begin
            res_idx = last_tok.idx_transit[OUT_IDX_W-1:0];
        end
        else if (last_tok.have_idle)
        begin
            res_idx = last_tok.idx_idle[OUT_IDX_W-1:0];
        end
        else
        begin
            res_idx = '0;
        end
    end

    // Track a request in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (accept && (opcode == OP_REQUEST))
        begin
            busy_reg <= 1'b1;
        end
        else if (finish)
        begin
            busy_reg <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            found_reg  <= res_found;
            chosen_reg <= res_idx;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign chosen_car = chosen_reg;

endmodule
